@@ sv/quad_x_mixer_with_cap_top_macros.svh @@
// ----------------------------------------------------------------------------
// quad x mixer assertion macros
// Concurrent assertion forms for the mixer's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef QUAD_X_MIXER_WITH_CAP_TOP_MACROS_SVH
`define QUAD_X_MIXER_WITH_CAP_TOP_MACROS_SVH

// checked on every clock edge outside reset
`define QXM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define QXM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/qxm_pkg.sv @@
// ----------------------------------------------------------------------------
// qxm_pkg
// Types and constants of the quadrotor x-frame mixer with common cap.
// ----------------------------------------------------------------------------
package qxm_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int CMD_W       = 16;
  localparam int SHIFT_W     = 15;
  localparam int GAIN_W      = 17;  // signed q2.14 gain before clamping
  localparam int GAIN_SHIFT  = 14;
  localparam int PROD_W      = 32;
  localparam int MIX_W       = 18;  // signed mixed value, no wrap
  localparam int CAPV_W      = 19;  // signed mixed value minus reduction
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int CAP_LIMIT   = 30000;
  localparam int GAIN_ONE    = 16384;

  // one bit per motor, set where the term is subtracted
  localparam logic [MOTOR_COUNT-1:0] NEG_X = 4'b0110;
  localparam logic [MOTOR_COUNT-1:0] NEG_Y = 4'b0011;
  localparam logic [MOTOR_COUNT-1:0] NEG_R = 4'b0011;
  localparam logic [MOTOR_COUNT-1:0] NEG_P = 4'b0110;
  localparam logic [MOTOR_COUNT-1:0] NEG_W = 4'b1010;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHIFT_X = 2'd0,
    REG_SHIFT_Y = 2'd1,
    REG_IDLE    = 2'd2
  } cfg_reg_e;

  typedef logic signed [MIX_W-1:0] mix_t;

  typedef struct packed {
    logic signed [SHIFT_W-1:0] shift_x_ratio;
    logic signed [SHIFT_W-1:0] shift_y_ratio;
    logic        [CMD_W-1:0]   idle_level;
  } cfg_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] roll_cmd;
    logic signed [CMD_W-1:0] pitch_cmd;
    logic signed [CMD_W-1:0] yaw_cmd;
    logic        [CMD_W-1:0] thrust_cmd;
  } in_t;

  typedef struct packed {
    logic [CMD_W-1:0] motor_one;
    logic [CMD_W-1:0] motor_two;
    logic [CMD_W-1:0] motor_three;
    logic [CMD_W-1:0] motor_four;
    logic             was_capped;
  } out_t;

endpackage

@@ sv/qxm_mix.sv @@
// ----------------------------------------------------------------------------
// qxm_mix
// Per-motor thrust gain, thrust scaling and roll/pitch/yaw mixing.
// ----------------------------------------------------------------------------
module qxm_mix import qxm_pkg::*; (
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output mix_t mix_o [MOTOR_COUNT]
);

  logic signed [GAIN_W-1:0] sx_w;
  logic signed [GAIN_W-1:0] sy_w;
  logic signed [MIX_W-1:0]  roll_w;
  logic signed [MIX_W-1:0]  pitch_w;
  logic signed [MIX_W-1:0]  yaw_w;
  logic signed [MIX_W-1:0]  roll_sum;
  logic signed [MIX_W-1:0]  pitch_sum;
  logic signed [MIX_W-1:0]  r_w;
  logic signed [MIX_W-1:0]  p_w;

  assign sx_w    = GAIN_W'(cfg_i.shift_x_ratio);
  assign sy_w    = GAIN_W'(cfg_i.shift_y_ratio);
  assign roll_w  = MIX_W'(in_i.roll_cmd);
  assign pitch_w = MIX_W'(in_i.pitch_cmd);
  assign yaw_w   = MIX_W'(in_i.yaw_cmd);

  // halve toward zero: add one to negative values before the shift
  assign roll_sum  = roll_w + $signed({{(MIX_W-1){1'b0}}, roll_w[MIX_W-1]});
  assign pitch_sum = pitch_w + $signed({{(MIX_W-1){1'b0}}, pitch_w[MIX_W-1]});
  assign r_w = roll_sum >>> 1;
  assign p_w = pitch_sum >>> 1;

  for (genvar k = 0; k < MOTOR_COUNT; k++) begin : g_motor
    logic signed [GAIN_W-1:0] gain;
    logic        [GAIN_W-2:0] gain_pos;
    logic        [PROD_W-1:0] prod;
    logic        [CMD_W-1:0]  thrust_k;
    logic signed [MIX_W-1:0]  thrust_w;

    assign gain = GAIN_W'(GAIN_ONE) + (NEG_X[k] ? -sx_w : sx_w)
                + (NEG_Y[k] ? -sy_w : sy_w);
    assign gain_pos = gain[GAIN_W-1] ? '0 : gain[GAIN_W-2:0];
    assign prod = PROD_W'(gain_pos) * PROD_W'(in_i.thrust_cmd);
    // saturate when the shifted product no longer fits in 16 bits
    assign thrust_k = (|prod[PROD_W-1:GAIN_SHIFT+CMD_W]) ? '1
                    : prod[GAIN_SHIFT+CMD_W-1:GAIN_SHIFT];
    assign thrust_w = $signed({{(MIX_W-CMD_W){1'b0}}, thrust_k});

    assign mix_o[k] = thrust_w + (NEG_R[k] ? -r_w : r_w)
                    + (NEG_P[k] ? -p_w : p_w)
                    + (NEG_W[k] ? -yaw_w : yaw_w);
  end

endmodule

@@ sv/qxm_cap.sv @@
// ----------------------------------------------------------------------------
// qxm_cap
// Common reduction from the highest mixed value and idle floor per motor.
// ----------------------------------------------------------------------------
module qxm_cap import qxm_pkg::*; (
  input  mix_t             mix_i [MOTOR_COUNT],
  input  logic [CMD_W-1:0] idle_i,
  output out_t             out_o
);

  mix_t                     max_01;
  mix_t                     max_23;
  mix_t                     max_all;
  mix_t                     highest;
  mix_t                     reduction;
  logic                     capped;
  logic signed [CAPV_W-1:0] idle_w;
  logic        [CMD_W-1:0]  motor [MOTOR_COUNT];

  assign max_01  = (mix_i[0] > mix_i[1]) ? mix_i[0] : mix_i[1];
  assign max_23  = (mix_i[2] > mix_i[3]) ? mix_i[2] : mix_i[3];
  assign max_all = (max_01 > max_23) ? max_01 : max_23;
  // search starts at zero
  assign highest = max_all[MIX_W-1] ? '0 : max_all;

  assign capped    = highest > MIX_W'(CAP_LIMIT);
  assign reduction = capped ? highest - MIX_W'(CAP_LIMIT) : '0;
  assign idle_w    = $signed({{(CAPV_W-CMD_W){1'b0}}, idle_i});

  for (genvar k = 0; k < MOTOR_COUNT; k++) begin : g_floor
    logic signed [CAPV_W-1:0] v;
    assign v = CAPV_W'(mix_i[k]) - CAPV_W'(reduction);
    assign motor[k] = (v < idle_w) ? idle_i : v[CMD_W-1:0];
  end

  always_comb begin
    out_o.motor_one   = motor[0];
    out_o.motor_two   = motor[1];
    out_o.motor_three = motor[2];
    out_o.motor_four  = motor[3];
    out_o.was_capped  = capped;
  end

endmodule

@@ sv/quad_x_mixer_with_cap_top.sv @@
// ----------------------------------------------------------------------------
// quad_x_mixer_with_cap_top
// Quadrotor x-frame motor mixer with common upper cap and idle floor.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------
//   in      | input     | in_valid_i / in_stall_o | in_data_i
//   out     | output    | out_valid_o/out_stall_i | out_data_o
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled;
// out_valid_o rises after the accepting edge through the input register, mix
// register (gain multipliers) and result register (cap and floor).
// reset clears the stage valid bits and all configuration registers.
// in_stall_o rises only when all three stages hold a transaction and the
// output is stalled; bubbles in between are squeezed out.
// ----------------------------------------------------------------------------
`include "quad_x_mixer_with_cap_top_macros.svh"

module quad_x_mixer_with_cap_top import qxm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic s1_valid_q, s1_valid_d;
  in_t  s1_data_q;
  logic s2_valid_q, s2_valid_d;
  mix_t mix_q [MOTOR_COUNT];
  mix_t mix_d [MOTOR_COUNT];
  logic out_valid_q, out_valid_d;
  out_t out_data_q, out_data_d;
  logic out_en, s2_en, s1_en;

  // stage enables ripple back from the output
  assign out_en     = !out_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;

  assign s1_valid_d  = s1_en ? in_valid_i : s1_valid_q;
  assign s2_valid_d  = s2_en ? s1_valid_q : s2_valid_q;
  assign out_valid_d = out_en ? s2_valid_q : out_valid_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SHIFT_X: cfg_d.shift_x_ratio = cfg_data_i[SHIFT_W-1:0];
        REG_SHIFT_Y: cfg_d.shift_y_ratio = cfg_data_i[SHIFT_W-1:0];
        REG_IDLE:    cfg_d.idle_level    = cfg_data_i[CMD_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  qxm_mix u_mix (
    .in_i  (s1_data_q),
    .cfg_i (cfg_q),
    .mix_o (mix_d)
  );

  qxm_cap u_cap (
    .mix_i  (mix_q),
    .idle_i (cfg_q.idle_level),
    .out_o  (out_data_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_data_q <= in_data_i;
    end
    if (s2_en) begin
      mix_q <= mix_d;
    end
    if (out_en) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `QXM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !s1_valid_q && !s2_valid_q && !out_valid_q, "stage valid set in reset")
  `QXM_ASSERT(a_stall_full, in_stall_o |-> s1_valid_q && s2_valid_q && out_valid_q, "input stalled with a free stage")
  `QXM_ASSERT(a_s1_advance, s1_valid_q && s2_en |=> s2_valid_q, "transaction lost between input and mix stage")
  `QXM_ASSERT(a_s2_hold, s2_valid_q && !out_en |=> s2_valid_q && $stable(mix_q[0]), "stalled mix stage changed")

endmodule

@@ test/quad_x_mixer_with_cap_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_mixer_with_cap_checker
// Watches the command, result and register ports of the mixer, works out the
// expected motor values for each accepted command and compares them in order.
// ----------------------------------------------------------------------------
module quad_x_mixer_with_cap_checker import qxm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_t                   in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_t                  out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    capped_o
);

  localparam int CAP_LEVEL   = 30000;
  localparam int UNITY_GAIN  = 16384;
  localparam int PWM_CEILING = 65535;

  logic signed [SHIFT_W-1:0] shift_x_q;
  logic signed [SHIFT_W-1:0] shift_y_q;
  logic        [CMD_W-1:0]   idle_q;

  out_t motor_queue[$];

  // per-motor thrust after the center-of-mass gain, q2.14
  function automatic int thrust_share(int gain, int thrust);
    longint prod;
    if (gain < 0) gain = 0;
    prod = (longint'(gain) * longint'(thrust)) >>> 14;
    if (prod > PWM_CEILING) prod = PWM_CEILING;
    return int'(prod);
  endfunction

  function automatic out_t mix_motors(in_t cmd);
    int   sx;
    int   sy;
    int   r;
    int   p;
    int   w;
    int   t;
    int   peak;
    int   cut;
    int   v;
    int   mixed [MOTOR_COUNT];
    logic [CMD_W-1:0] motor [MOTOR_COUNT];
    out_t res;
    sx = int'(shift_x_q);
    sy = int'(shift_y_q);
    r  = int'(cmd.roll_cmd);
    p  = int'(cmd.pitch_cmd);
    w  = int'(cmd.yaw_cmd);
    t  = int'(cmd.thrust_cmd);
    // roll and pitch halve toward zero
    r  = r / 2;
    p  = p / 2;
    mixed[0] = thrust_share(UNITY_GAIN + sx - sy, t) - r + p + w;
    mixed[1] = thrust_share(UNITY_GAIN - sx - sy, t) - r - p - w;
    mixed[2] = thrust_share(UNITY_GAIN - sx + sy, t) + r - p + w;
    mixed[3] = thrust_share(UNITY_GAIN + sx + sy, t) + r + p - w;
    peak = 0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      if (mixed[k] > peak) peak = mixed[k];
    end
    cut = (peak > CAP_LEVEL) ? peak - CAP_LEVEL : 0;
    for (int k = 0; k < MOTOR_COUNT; k++) begin
      v = mixed[k] - cut;
      if (v < int'(idle_q)) v = int'(idle_q);
      motor[k] = v[CMD_W-1:0];
    end
    res.motor_one   = motor[0];
    res.motor_two   = motor[1];
    res.motor_three = motor[2];
    res.motor_four  = motor[3];
    res.was_capped  = (peak > CAP_LEVEL);
    return res;
  endfunction

  task automatic check_field(string field, int want, int got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      shift_x_q = '0;
      shift_y_q = '0;
      idle_q    = '0;
      motor_queue.delete();
      fail_count_o = 0;
      checked_o    = 0;
      capped_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (motor_queue.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result transaction with nothing expected, got %h", $time,
                   out_data_i);
        end else begin
          want = motor_queue.pop_front();
          check_field("motor_one", int'(want.motor_one), int'(out_data_i.motor_one));
          check_field("motor_two", int'(want.motor_two), int'(out_data_i.motor_two));
          check_field("motor_three", int'(want.motor_three),
                      int'(out_data_i.motor_three));
          check_field("motor_four", int'(want.motor_four), int'(out_data_i.motor_four));
          check_field("was_capped", int'(want.was_capped), int'(out_data_i.was_capped));
          checked_o++;
          if (want.was_capped) capped_o++;
        end
      end
      if (in_valid_i && !in_stall_i) motor_queue.push_back(mix_motors(in_data_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SHIFT_X: shift_x_q = cfg_data_i[SHIFT_W-1:0];
          REG_SHIFT_Y: shift_y_q = cfg_data_i[SHIFT_W-1:0];
          REG_IDLE:    idle_q    = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = motor_queue.size();
  end

endmodule

@@ test/quad_x_mixer_with_cap_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_x_mixer_with_cap_top_tb
// Drives roll, pitch, yaw and thrust commands into the mixer under a series of
// center-of-mass shifts and idle floors, with bursty input and random output
// stalls; a separate checker predicts and compares every motor result.
// ----------------------------------------------------------------------------
module quad_x_mixer_with_cap_top_tb;
  import qxm_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1330;
  localparam int RANDOM_PHASES = 8;
  localparam int HOLD_OFF      = 150;
  localparam int HOLD_BURST    = 30;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int checked;
  int capped;
  int sent;
  int settings;
  int quiet;
  int stalled_in;
  int holds;
  int hold_left;
  int stretch_left;
  int stall_mode;
  bit hold_off_req;

  quad_x_mixer_with_cap_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  quad_x_mixer_with_cap_checker motor_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .capped_o     (capped)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: random stall stretches, plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left    = HOLD_OFF - 1;
      holds++;
      out_stall <= 1'b1;
    end else begin
      if (stretch_left == 0) begin
        stall_mode   = $urandom_range(0, 3);
        stretch_left = $urandom_range(1, 40);
      end
      stretch_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= 1'b1;
      endcase
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (in_valid && in_stall) stalled_in++;
      if (quiet >= IDLE_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("quad_x_mixer_with_cap_top_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_cmd(in_t cmd);
    bit taken;
    in_valid <= 1'b1;
    in_data  <= cmd;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sent++;
  endtask

  task automatic send_fields(int roll, int pitch, int yaw, int thrust);
    in_t cmd;
    cmd.roll_cmd   = roll[CMD_W-1:0];
    cmd.pitch_cmd  = pitch[CMD_W-1:0];
    cmd.yaw_cmd    = yaw[CMD_W-1:0];
    cmd.thrust_cmd = thrust[CMD_W-1:0];
    send_cmd(cmd);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_config(int sx, int sy, int floor_level);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHIFT_X;
    cfg_data  <= sx[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_SHIFT_Y;
    cfg_data  <= sy[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= REG_IDLE;
    cfg_data  <= floor_level[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [CMD_W-1:0] around(int centre, int span);
    int v;
    v = centre + int'($urandom_range(0, 2 * span)) - span;
    return v[CMD_W-1:0];
  endfunction

  function automatic logic [CMD_W-1:0] edge_cmd();
    case ($urandom_range(0, 4))
      0:       return 16'h8000;
      1:       return 16'hffff;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7fff;
    endcase
  endfunction

  function automatic int rand_shift();
    case ($urandom_range(0, 3))
      0:       return int'($urandom_range(0, 2000)) - 1000;
      1:       return int'($urandom_range(0, 32767)) - 16384;
      2:       return $urandom_range(0, 1) ? 16383 : -16384;
      default: return 0;
    endcase
  endfunction

  function automatic int rand_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return $urandom_range(0, 3000);
      2:       return $urandom_range(0, 65535);
      default: return $urandom_range(0, 1) ? 65535 : 30000;
    endcase
  endfunction

  function automatic in_t rand_cmd();
    in_t cmd;
    case ($urandom_range(0, 5))
      0, 1: cmd = {$urandom, $urandom};
      2, 3: begin
        // flight-like commands around hover
        cmd.roll_cmd   = around(0, 4000);
        cmd.pitch_cmd  = around(0, 4000);
        cmd.yaw_cmd    = around(0, 3000);
        cmd.thrust_cmd = around(30000, 15000);
      end
      4: begin
        // hugging the cap threshold
        cmd.roll_cmd   = around(0, 300);
        cmd.pitch_cmd  = around(0, 300);
        cmd.yaw_cmd    = around(0, 300);
        cmd.thrust_cmd = around(30000, 1000);
      end
      default: begin
        cmd.roll_cmd   = edge_cmd();
        cmd.pitch_cmd  = edge_cmd();
        cmd.yaw_cmd    = edge_cmd();
        cmd.thrust_cmd = $urandom_range(0, 1) ? edge_cmd() : 16'd30000;
      end
    endcase
    return cmd;
  endfunction

  initial begin
    int quota;
    int burst;
    int ph;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SHIFT_X;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no shift, no idle floor
    send_fields(0, 0, 0, 0);
    send_fields(0, 0, 0, 65535);
    send_fields(-32768, -32768, -32768, 0);
    send_fields(32767, 32767, 32767, 65535);
    send_fields(-1, 1, -1, 30000);
    send_fields(1, -1, 1, 30001);
    send_fields(-32768, 32767, -32768, 65535);
    send_fields(32767, -32768, 32767, 0);
    send_fields(0, 0, 32767, 10000);
    send_fields(0, 0, -32768, 10000);
    send_fields(-3, -3, 0, 100);
    send_fields(3, 3, 0, 100);

    // most negative shifts: one gain saturates thrust, one clamps to zero
    set_config(-16384, -16384, 0);
    send_fields(0, 0, 0, 65535);
    send_fields(0, 0, 0, 1000);

    // most positive shifts with the highest idle floor
    set_config(16383, 16383, 65535);
    send_fields(0, 0, 0, 65535);
    send_fields(-32768, -32768, -32768, 0);

    set_config(16383, -16384, 2000);
    send_fields(0, 0, 0, 65535);
    send_fields(1000, -1000, 500, 20000);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_config(rand_shift(), rand_shift(), rand_idle());
      quota = RANDOM_ITEMS / RANDOM_PHASES;
      if (ph == 1 || ph == 5) begin
        // long output hold-off while commands keep coming
        hold_off_req = 1'b1;
        repeat (HOLD_BURST) send_cmd(rand_cmd());
        quota -= HOLD_BURST;
      end
      while (quota > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > quota) burst = quota;
        repeat (burst) send_cmd(rand_cmd());
        quota -= burst;
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 10)) @(posedge clk);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d commands under %0d register settings, %0d results compared, %0d capped",
             sent, settings, checked, capped);
    $display("summary: input stalled %0d cycles, %0d long output hold-offs", stalled_in, holds);
    if (fail_count == 0 && pending == 0) begin
      $display("quad_x_mixer_with_cap_top_tb: done, clean");
    end else begin
      $display("quad_x_mixer_with_cap_top_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/qxm_pkg.sv
sv/qxm_mix.sv
sv/qxm_cap.sv
sv/quad_x_mixer_with_cap_top.sv
test/quad_x_mixer_with_cap_checker.sv
test/quad_x_mixer_with_cap_top_tb.sv
